### src/tsp_pkg.sv
package tsp_pkg;

  localparam int PulseW  = 15;
  localparam int StepW   = 10;
  localparam int FracW   = 16;
  localparam int ActW    = 3;
  localparam int RegIdxW = 3;

  typedef logic [PulseW-1:0] pulse_t;
  typedef logic [StepW-1:0]  step_t;
  typedef logic [FracW-1:0]  frac_t;

  typedef enum logic [ActW-1:0] {
    ACT_JOG_UP     = 3'd0,
    ACT_JOG_DOWN   = 3'd1,
    ACT_JOG_LEFT   = 3'd2,
    ACT_JOG_RIGHT  = 3'd3,
    ACT_SET_TARGET = 3'd4,
    ACT_TICK       = 3'd5
  } action_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_PITCH_LOW  = 3'd0,
    REG_PITCH_HIGH = 3'd1,
    REG_YAW_LOW    = 3'd2,
    REG_YAW_HIGH   = 3'd3,
    REG_JOG_STEP   = 3'd4,
    REG_SLEW_STEP  = 3'd5
  } reg_idx_t;

  // per-axis operation picked by the command decode
  typedef enum logic [2:0] {
    AX_HOLD  = 3'd0,
    AX_RAISE = 3'd1,
    AX_LOWER = 3'd2,
    AX_SET   = 3'd3,
    AX_SLEW  = 3'd4
  } axis_op_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    frac_t           pitch_fraction;
    frac_t           yaw_fraction;
  } cmd_t;

  typedef struct packed {
    pulse_t pitch_pulse;
    pulse_t yaw_pulse;
    logic   yaw_enable;
    logic   slewing;
  } rsp_t;

  typedef struct packed {
    logic [RegIdxW-1:0] reg_index;
    pulse_t             reg_value;
  } cfg_wr_t;

  typedef struct packed {
    pulse_t pitch_low;
    pulse_t pitch_high;
    pulse_t yaw_low;
    pulse_t yaw_high;
    step_t  jog_step;
    step_t  slew_step;
  } settings_t;

  localparam pulse_t PITCH_LOW_RST  = 15'd800;
  localparam pulse_t PITCH_HIGH_RST = 15'd1600;
  localparam pulse_t YAW_LOW_RST    = 15'd1100;
  localparam pulse_t YAW_HIGH_RST   = 15'd1800;
  localparam step_t  JOG_STEP_RST   = 10'd30;
  localparam step_t  SLEW_STEP_RST  = 10'd10;
  localparam pulse_t PITCH_POS_RST  = 15'd800;
  localparam pulse_t YAW_POS_RST    = 15'd1450;

endpackage

### src/tsp_if.sv
interface tsp_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/tsp_cfg_regs.sv
module tsp_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  tsp_if.sink                 cfg,
  output tsp_pkg::settings_t  settings
);

  tsp_pkg::settings_t regs;

  assign cfg.ready = 1'b1;
  assign settings  = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pitch_low  <= tsp_pkg::PITCH_LOW_RST;
      regs.pitch_high <= tsp_pkg::PITCH_HIGH_RST;
      regs.yaw_low    <= tsp_pkg::YAW_LOW_RST;
      regs.yaw_high   <= tsp_pkg::YAW_HIGH_RST;
      regs.jog_step   <= tsp_pkg::JOG_STEP_RST;
      regs.slew_step  <= tsp_pkg::SLEW_STEP_RST;
    end else if (cfg.valid) begin
      case (tsp_pkg::reg_idx_t'(cfg.data.reg_index))
        tsp_pkg::REG_PITCH_LOW:  regs.pitch_low  <= cfg.data.reg_value;
        tsp_pkg::REG_PITCH_HIGH: regs.pitch_high <= cfg.data.reg_value;
        tsp_pkg::REG_YAW_LOW:    regs.yaw_low    <= cfg.data.reg_value;
        tsp_pkg::REG_YAW_HIGH:   regs.yaw_high   <= cfg.data.reg_value;
        tsp_pkg::REG_JOG_STEP:   regs.jog_step   <= cfg.data.reg_value[tsp_pkg::StepW-1:0];
        tsp_pkg::REG_SLEW_STEP:  regs.slew_step  <= cfg.data.reg_value[tsp_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### src/tsp_axis.sv
// Next position and goal for one axis: jog with clamp, goal mapping, slew step.
module tsp_axis (
  input  tsp_pkg::axis_op_t op,
  input  tsp_pkg::pulse_t   pos,
  input  tsp_pkg::pulse_t   goal,
  input  tsp_pkg::pulse_t   low,
  input  tsp_pkg::pulse_t   high,
  input  tsp_pkg::step_t    jog_step,
  input  tsp_pkg::step_t    slew_step,
  input  tsp_pkg::frac_t    frac,
  output tsp_pkg::pulse_t   pos_next,
  output tsp_pkg::pulse_t   goal_next
);

  localparam int PW = tsp_pkg::PulseW;
  localparam int SW = tsp_pkg::StepW;
  localparam int FW = tsp_pkg::FracW;

  logic [PW-1:0]    jog_ext;
  logic [PW-1:0]    slew_ext;
  logic [PW:0]      raise_sum;
  logic [PW-1:0]    raise_pos;
  logic [PW-1:0]    lower_pos;
  logic [PW-1:0]    span;
  logic [PW+FW-1:0] prod;
  logic [PW:0]      mapped;
  logic [PW-1:0]    slew_pos;

  assign jog_ext  = {{(PW-SW){1'b0}}, jog_step};
  assign slew_ext = (slew_step == '0) ? {{(PW-1){1'b0}}, 1'b1}
                                      : {{(PW-SW){1'b0}}, slew_step};

  // jog up: unchanged at or past the limit, else step up and clamp to it
  assign raise_sum = {1'b0, pos} + {1'b0, jog_ext};
  always_comb begin
    if (pos >= high)
      raise_pos = pos;
    else if (raise_sum > {1'b0, high})
      raise_pos = high;
    else
      raise_pos = raise_sum[PW-1:0];
  end

  always_comb begin
    if (pos <= low)
      lower_pos = pos;
    else if ((pos - low) > jog_ext)
      lower_pos = pos - jog_ext;
    else
      lower_pos = low;
  end

  // goal = low + (span * frac) >> 16, reversed limits give zero span
  assign span   = (high > low) ? (high - low) : '0;
  assign prod   = {{FW{1'b0}}, span} * {{PW{1'b0}}, frac};
  assign mapped = {1'b0, low} + {1'b0, prod[PW+FW-1:FW]};

  // snap onto the goal when within one step
  always_comb begin
    if (pos < goal)
      slew_pos = ((goal - pos) <= slew_ext) ? goal : pos + slew_ext;
    else if (pos > goal)
      slew_pos = ((pos - goal) <= slew_ext) ? goal : pos - slew_ext;
    else
      slew_pos = pos;
  end

  always_comb begin
    pos_next  = pos;
    goal_next = goal;
    case (op)
      tsp_pkg::AX_RAISE: pos_next  = raise_pos;
      tsp_pkg::AX_LOWER: pos_next  = lower_pos;
      tsp_pkg::AX_SET:   goal_next = mapped[PW-1:0];
      tsp_pkg::AX_SLEW:  pos_next  = slew_pos;
      default: ;
    endcase
  end

endmodule

### src/two_axis_servo_slew_positioner.sv
// Channel  Dir  Payload                                       Role
// -------  ---  --------------------------------------------  --------------------------
// cmd      in   action, pitch_fraction, yaw_fraction          jog / set target / tick
// rsp      out  pitch_pulse, yaw_pulse, yaw_enable, slewing   state after each command
// cfg      in   reg_index, reg_value                          limit and step registers
//
// One command per cycle sustained while rsp is ready; rsp valid rises once the
// cmd transaction has passed the command register, then the result register.
// Each command yields exactly one rsp transaction.
// rst is synchronous: limits/steps to defaults, pitch 800, yaw 1450, idle.
// A stalled rsp holds the result register; cmd keeps taking a transaction
// while the command register is empty or can move into the result register.
module two_axis_servo_slew_positioner (
  input logic clk,
  input logic rst,
  tsp_if.sink   cmd,
  tsp_if.source rsp,
  tsp_if.sink   cfg
);

  tsp_pkg::settings_t settings;

  // command register
  logic          s1_valid;
  tsp_pkg::cmd_t s1_cmd;
  logic          adv;

  // positioner state
  tsp_pkg::pulse_t pitch_pos;
  tsp_pkg::pulse_t yaw_pos;
  tsp_pkg::pulse_t pitch_goal;
  tsp_pkg::pulse_t yaw_goal;
  logic            slew_active;

  tsp_pkg::pulse_t pitch_pos_next;
  tsp_pkg::pulse_t yaw_pos_next;
  tsp_pkg::pulse_t pitch_goal_next;
  tsp_pkg::pulse_t yaw_goal_next;
  logic            slew_active_next;
  logic            off_goal;

  tsp_pkg::axis_op_t pitch_op;
  tsp_pkg::axis_op_t yaw_op;

  // result register
  logic          out_valid;
  tsp_pkg::rsp_t out_data;

  tsp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  // command register moves on when the result register is free or draining
  assign adv       = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !s1_valid || !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_cmd <= cmd.data;
    end
  end

  // decode: jogs are ignored while a slew is in progress, ticks only act while slewing
  always_comb begin
    pitch_op = tsp_pkg::AX_HOLD;
    yaw_op   = tsp_pkg::AX_HOLD;
    case (tsp_pkg::action_t'(s1_cmd.action))
      tsp_pkg::ACT_JOG_UP:     if (!slew_active) pitch_op = tsp_pkg::AX_RAISE;
      tsp_pkg::ACT_JOG_DOWN:   if (!slew_active) pitch_op = tsp_pkg::AX_LOWER;
      tsp_pkg::ACT_JOG_LEFT:   if (!slew_active) yaw_op   = tsp_pkg::AX_LOWER;
      tsp_pkg::ACT_JOG_RIGHT:  if (!slew_active) yaw_op   = tsp_pkg::AX_RAISE;
      tsp_pkg::ACT_SET_TARGET: begin
        pitch_op = tsp_pkg::AX_SET;
        yaw_op   = tsp_pkg::AX_SET;
      end
      tsp_pkg::ACT_TICK: begin
        if (slew_active) begin
          pitch_op = tsp_pkg::AX_SLEW;
          yaw_op   = tsp_pkg::AX_SLEW;
        end
      end
      default: ;
    endcase
  end

  tsp_axis u_pitch (
    .op        (pitch_op),
    .pos       (pitch_pos),
    .goal      (pitch_goal),
    .low       (settings.pitch_low),
    .high      (settings.pitch_high),
    .jog_step  (settings.jog_step),
    .slew_step (settings.slew_step),
    .frac      (s1_cmd.pitch_fraction),
    .pos_next  (pitch_pos_next),
    .goal_next (pitch_goal_next)
  );

  tsp_axis u_yaw (
    .op        (yaw_op),
    .pos       (yaw_pos),
    .goal      (yaw_goal),
    .low       (settings.yaw_low),
    .high      (settings.yaw_high),
    .jog_step  (settings.jog_step),
    .slew_step (settings.slew_step),
    .frac      (s1_cmd.yaw_fraction),
    .pos_next  (yaw_pos_next),
    .goal_next (yaw_goal_next)
  );

  assign off_goal = (pitch_pos_next != pitch_goal_next) || (yaw_pos_next != yaw_goal_next);

  // set target (re)starts the slew; a tick ends it once both axes land
  always_comb begin
    case (tsp_pkg::action_t'(s1_cmd.action))
      tsp_pkg::ACT_SET_TARGET: slew_active_next = off_goal;
      tsp_pkg::ACT_TICK:       slew_active_next = slew_active && off_goal;
      default:                 slew_active_next = slew_active;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_pos   <= tsp_pkg::PITCH_POS_RST;
      yaw_pos     <= tsp_pkg::YAW_POS_RST;
      pitch_goal  <= '0;
      yaw_goal    <= '0;
      slew_active <= 1'b0;
    end else if (adv) begin
      pitch_pos   <= pitch_pos_next;
      yaw_pos     <= yaw_pos_next;
      pitch_goal  <= pitch_goal_next;
      yaw_goal    <= yaw_goal_next;
      slew_active <= slew_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.pitch_pulse <= pitch_pos_next;
      out_data.yaw_pulse   <= yaw_pos_next;
      out_data.yaw_enable  <= slew_active_next;
      out_data.slewing     <= slew_active_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

`ifndef SYNTHESIS
  // an active slew always has somewhere left to go
  assert property (@(posedge clk) disable iff (rst)
    slew_active |-> ((pitch_pos != pitch_goal) || (yaw_pos != yaw_goal)))
    else $error("slew active with both axes on goal");

  // a tick while idle moves nothing
  assert property (@(posedge clk) disable iff (rst)
    (adv && !slew_active && (s1_cmd.action == tsp_pkg::ACT_TICK))
      |=> ($stable(pitch_pos) && $stable(yaw_pos)))
    else $error("idle tick changed a position");

  // commands back up only behind a full, stalled result register
  assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (s1_valid && out_valid && !rsp.ready))
    else $error("cmd stalled without back pressure");

  // jogs never move an axis during a slew
  assert property (@(posedge clk) disable iff (rst)
    (adv && slew_active && (s1_cmd.action != tsp_pkg::ACT_SET_TARGET)
         && (s1_cmd.action != tsp_pkg::ACT_TICK))
      |=> ($stable(pitch_pos) && $stable(yaw_pos)))
    else $error("jog moved an axis while slewing");
`endif

endmodule
